FILE: rtl/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
`default_nettype none
package qrs_pkg;

  // Coefficient and root width; the request and result types are built on it.
  localparam int COEF_WIDTH = 32;
  // Width of the zero tolerance register.
  localparam int TOL_WIDTH = 31;

  // Kind of solution set found for one request.
  typedef enum logic [2:0] {
    CLS_ALL_REAL = 3'd0,
    CLS_NONE     = 3'd1,
    CLS_LINEAR   = 3'd2,
    CLS_DOUBLE   = 3'd3,
    CLS_NO_REAL  = 3'd4,
    CLS_TWO      = 3'd5
  } qrs_class_t;

  // One coefficient triple, signed fixed point.
  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;
  } qrs_req_t;

  // One result: class, up to two roots and the clamp flag.
  typedef struct packed {
    qrs_class_t                   root_class;
    logic signed [COEF_WIDTH-1:0] root_first;
    logic signed [COEF_WIDTH-1:0] root_second;
    logic                         saturated;
  } qrs_res_t;

endpackage
`default_nettype wire

FILE: rtl/qrs_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
`default_nettype none
module qrs_isqrt #(
  parameter int D_WIDTH   = 66,
  parameter int TAG_WIDTH = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic [D_WIDTH-1:0]   in_d,
  input  wire logic [TAG_WIDTH-1:0] in_tag,
  output logic                      out_valid,
  output logic [D_WIDTH/2-1:0]      out_root,
  output logic [TAG_WIDTH-1:0]      out_tag
);

  localparam int SW = D_WIDTH / 2;
  localparam int RW = SW + 2;

  logic                 v_r    [SW];
  logic [RW-1:0]        rem_r  [SW];
  logic [SW-1:0]        root_r [SW];
  logic [D_WIDTH-1:0]   d_r    [SW];
  logic [TAG_WIDTH-1:0] tag_r  [SW];

  for (genvar i = 0; i < SW; i++) begin : g_stage
    logic                 v_p;
    logic [RW-1:0]        rem_p;
    logic [SW-1:0]        root_p;
    logic [D_WIDTH-1:0]   d_p;
    logic [TAG_WIDTH-1:0] tag_p;
    logic [RW:0]          rem_t;
    logic [RW:0]          trial;
    logic                 ge;

    // The first stage takes the request, the others the stage before.
    if (i == 0) begin : g_first
      assign v_p    = in_valid;
      assign rem_p  = '0;
      assign root_p = '0;
      assign d_p    = in_d;
      assign tag_p  = in_tag;
    end else begin : g_next
      assign v_p    = v_r[i-1];
      assign rem_p  = rem_r[i-1];
      assign root_p = root_r[i-1];
      assign d_p    = d_r[i-1];
      assign tag_p  = tag_r[i-1];
    end

    // Bring down the next two radicand bits and try a one in this position.
    assign rem_t = {rem_p[RW-2:0], d_p[D_WIDTH-1 -: 2]};
    assign trial = {1'b0, root_p, 2'b01};
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i]  <= ge ? RW'(rem_t - trial) : RW'(rem_t);
      root_r[i] <= {root_p[SW-2:0], ge};
      d_r[i]    <= d_p << 2;
      tag_r[i]  <= tag_p;
    end
  end

  assign out_valid = v_r[SW-1];
  assign out_root  = root_r[SW-1];
  assign out_tag   = tag_r[SW-1];

endmodule
`default_nettype wire

FILE: rtl/qrs_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module qrs_div #(
  parameter int NUM_WIDTH = 50,
  parameter int DEN_WIDTH = 33,
  parameter int TAG_WIDTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic [NUM_WIDTH-1:0] in_num,
  input  wire logic [DEN_WIDTH-1:0] in_den,
  input  wire logic [TAG_WIDTH-1:0] in_tag,
  output logic                      out_valid,
  output logic [NUM_WIDTH-1:0]      out_quot,
  output logic [DEN_WIDTH-1:0]      out_rem,
  output logic [DEN_WIDTH-1:0]      out_den,
  output logic [TAG_WIDTH-1:0]      out_tag
);

  // The numerator shifts out at the top while quotient bits shift in below.
  logic                 v_r   [NUM_WIDTH];
  logic [NUM_WIDTH-1:0] nq_r  [NUM_WIDTH];
  logic [DEN_WIDTH-1:0] rem_r [NUM_WIDTH];
  logic [DEN_WIDTH-1:0] den_r [NUM_WIDTH];
  logic [TAG_WIDTH-1:0] tag_r [NUM_WIDTH];

  for (genvar i = 0; i < NUM_WIDTH; i++) begin : g_stage
    logic                 v_p;
    logic [NUM_WIDTH-1:0] nq_p;
    logic [DEN_WIDTH-1:0] rem_p;
    logic [DEN_WIDTH-1:0] den_p;
    logic [TAG_WIDTH-1:0] tag_p;
    logic [DEN_WIDTH:0]   r_t;
    logic [DEN_WIDTH:0]   diff;
    logic                 ge;

    if (i == 0) begin : g_first
      assign v_p   = in_valid;
      assign nq_p  = in_num;
      assign rem_p = '0;
      assign den_p = in_den;
      assign tag_p = in_tag;
    end else begin : g_next
      assign v_p   = v_r[i-1];
      assign nq_p  = nq_r[i-1];
      assign rem_p = rem_r[i-1];
      assign den_p = den_r[i-1];
      assign tag_p = tag_r[i-1];
    end

    // Shift in one numerator bit and subtract the divisor if it fits.
    assign r_t  = {rem_p, nq_p[NUM_WIDTH-1]};
    assign diff = r_t - {1'b0, den_p};
    assign ge   = r_t >= {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      nq_r[i]  <= {nq_p[NUM_WIDTH-2:0], ge};
      rem_r[i] <= ge ? diff[DEN_WIDTH-1:0] : r_t[DEN_WIDTH-1:0];
      den_r[i] <= den_p;
      tag_r[i] <= tag_p;
    end
  end

  assign out_valid = v_r[NUM_WIDTH-1];
  assign out_quot  = nq_r[NUM_WIDTH-1];
  assign out_rem   = rem_r[NUM_WIDTH-1];
  assign out_den   = den_r[NUM_WIDTH-1];
  assign out_tag   = tag_r[NUM_WIDTH-1];

endmodule
`default_nettype wire

FILE: rtl/quadratic_root_solver.sv
// Top level of the pipelined quadratic root solver.
//
// A request is one coefficient triple a, b, c on in_req, signed fixed
// point with FRAC_BITS fraction bits. It is taken at a rising edge where
// start is high and busy is low; busy never rises, so a request may be
// given in every cycle. Each request yields exactly one result on out_res,
// marked by out_valid for a single cycle, in request order.
// The tolerance register must be loaded through cfg_we and cfg_wdata only
// while no request is in flight; the block itself does not enforce this.
// The pipeline depth is set by the square root, one result bit per
// stage, and by the two root dividers, one quotient bit per stage.
// Throughput is one request per cycle.
// A synchronous reset clears the tolerance and every valid bit in the
// pipeline; requests in flight are dropped. The receiver cannot stall:
// results are presented once and must be taken.
`default_nettype none
module quadratic_root_solver #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire qrs_pkg::qrs_req_t            in_req,
  output logic                              out_valid,
  output qrs_pkg::qrs_res_t                 out_res,
  input  wire logic                         cfg_we,
  input  wire logic [qrs_pkg::TOL_WIDTH-1:0] cfg_wdata
);

  import qrs_pkg::*;

  localparam int W    = COEF_WIDTH;
  localparam int DW   = 2 * W + 2;
  localparam int SW   = DW / 2;
  localparam int NW   = W + 3;
  localparam int NMW  = W + 2;
  localparam int DVW  = W + 1;
  localparam int QW   = NMW + FRAC_BITS;
  localparam int TW   = (W > TOL_WIDTH) ? W : TOL_WIDTH;
  localparam int TDW  = (DW > TOL_WIDTH + FRAC_BITS) ? DW : TOL_WIDTH + FRAC_BITS;
  localparam int SQTW = 6 + 3 * W;
  localparam int LAT  = 9 + SW + QW;

  localparam logic [QW:0]  HALF_Q  = (QW + 1)'(1) << (W - 1);
  localparam logic [W-1:0] ROOT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] ROOT_MIN = {1'b1, {(W-1){1'b0}}};

  // Tolerance register.
  logic [TOL_WIDTH-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // Stage 1: signs and magnitudes.
  logic         v1_r, sa1_r, sb1_r, sc1_r;
  logic [W-1:0] ma1_r, mb1_r, mc1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    sa1_r <= in_req.coef_a[W-1];
    sb1_r <= in_req.coef_b[W-1];
    sc1_r <= in_req.coef_c[W-1];
    ma1_r <= in_req.coef_a[W-1] ? (~$unsigned(in_req.coef_a) + 1'b1) : $unsigned(in_req.coef_a);
    mb1_r <= in_req.coef_b[W-1] ? (~$unsigned(in_req.coef_b) + 1'b1) : $unsigned(in_req.coef_b);
    mc1_r <= in_req.coef_c[W-1] ? (~$unsigned(in_req.coef_c) + 1'b1) : $unsigned(in_req.coef_c);
  end

  // Stage 2: near-zero tests and the two products.
  logic           v2_r, sa2_r, sb2_r, sc2_r, nza2_r, nzb2_r, nzc2_r;
  logic [W-1:0]   ma2_r, mb2_r, mc2_r;
  logic [2*W-1:0] bb2_r, ac2_r;
  logic [TW-1:0]  tol_w;

  assign tol_w = TW'(tol_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    sa2_r  <= sa1_r;
    sb2_r  <= sb1_r;
    sc2_r  <= sc1_r;
    ma2_r  <= ma1_r;
    mb2_r  <= mb1_r;
    mc2_r  <= mc1_r;
    nza2_r <= (ma1_r == '0) || (TW'(ma1_r) < tol_w);
    nzb2_r <= (mb1_r == '0) || (TW'(mb1_r) < tol_w);
    nzc2_r <= (mc1_r == '0) || (TW'(mc1_r) < tol_w);
    bb2_r  <= mb1_r * mb1_r;
    ac2_r  <= ma1_r * mc1_r;
  end

  // Stage 3: sum and difference of b*b and 4*a*c.
  logic          v3_r, sa3_r, sb3_r, sc3_r, nza3_r, nzb3_r, nzc3_r;
  logic [W-1:0]  ma3_r, mb3_r, mc3_r;
  logic [DW-1:0] sum3_r;
  logic [DW:0]   diff3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    sa3_r   <= sa2_r;
    sb3_r   <= sb2_r;
    sc3_r   <= sc2_r;
    ma3_r   <= ma2_r;
    mb3_r   <= mb2_r;
    mc3_r   <= mc2_r;
    nza3_r  <= nza2_r;
    nzb3_r  <= nzb2_r;
    nzc3_r  <= nzc2_r;
    sum3_r  <= {2'b00, bb2_r} + {ac2_r, 2'b00};
    diff3_r <= {3'b000, bb2_r} - {1'b0, ac2_r, 2'b00};
  end

  // Stage 4: discriminant magnitude and sign.
  logic          v4_r, sa4_r, sb4_r, sc4_r, nza4_r, nzb4_r, nzc4_r, dneg4_r;
  logic [W-1:0]  ma4_r, mb4_r, mc4_r;
  logic [DW-1:0] dmag4_r;
  logic          opp3;

  assign opp3 = sa3_r != sc3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    sa4_r   <= sa3_r;
    sb4_r   <= sb3_r;
    sc4_r   <= sc3_r;
    ma4_r   <= ma3_r;
    mb4_r   <= mb3_r;
    mc4_r   <= mc3_r;
    nza4_r  <= nza3_r;
    nzb4_r  <= nzb3_r;
    nzc4_r  <= nzc3_r;
    dneg4_r <= !opp3 && diff3_r[DW];
    if (opp3) begin
      dmag4_r <= sum3_r;
    end else if (diff3_r[DW]) begin
      dmag4_r <= ~diff3_r[DW-1:0] + 1'b1;
    end else begin
      dmag4_r <= diff3_r[DW-1:0];
    end
  end

  // Stage 5: classify the equation.
  logic          v5_r, sa5_r, sb5_r, sc5_r;
  logic [W-1:0]  ma5_r, mb5_r, mc5_r;
  logic [DW-1:0] d5_r;
  qrs_class_t    cls5_r;
  qrs_class_t    cls_nxt;
  logic          nzd;

  always_comb begin
    nzd = (dmag4_r == '0) || (TDW'(dmag4_r) < (TDW'(tol_r) << FRAC_BITS));
    if (nza4_r) begin
      if (nzb4_r) begin
        cls_nxt = nzc4_r ? CLS_ALL_REAL : CLS_NONE;
      end else begin
        cls_nxt = CLS_LINEAR;
      end
    end else if (nzd) begin
      cls_nxt = CLS_DOUBLE;
    end else if (dneg4_r) begin
      cls_nxt = CLS_NO_REAL;
    end else begin
      cls_nxt = CLS_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    sa5_r  <= sa4_r;
    sb5_r  <= sb4_r;
    sc5_r  <= sc4_r;
    ma5_r  <= ma4_r;
    mb5_r  <= mb4_r;
    mc5_r  <= mc4_r;
    d5_r   <= dmag4_r;
    cls5_r <= cls_nxt;
  end

  // Square root of the discriminant, side data riding along.
  logic            sq_valid;
  logic [SW-1:0]   sq_root;
  logic [SQTW-1:0] sq_tag;

  qrs_isqrt #(
    .D_WIDTH   (DW),
    .TAG_WIDTH (SQTW)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v5_r),
    .in_d      (d5_r),
    .in_tag    ({cls5_r, sa5_r, sb5_r, sc5_r, ma5_r, mb5_r, mc5_r}),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  logic [2:0]   sq_cls;
  logic         sq_sa, sq_sb, sq_sc;
  logic [W-1:0] sq_ma, sq_mb, sq_mc;
  logic [NW-1:0] neg_b;

  assign {sq_cls, sq_sa, sq_sb, sq_sc, sq_ma, sq_mb, sq_mc} = sq_tag;
  assign neg_b = sq_sb ? {3'b000, sq_mb} : (~{3'b000, sq_mb} + 1'b1);

  // Stage 6: the two numerators -b + s and -b - s.
  logic          v6_r, sa6_r, sb6_r, sc6_r;
  logic [W-1:0]  ma6_r, mb6_r, mc6_r;
  logic [NW-1:0] n1_6_r, n2_6_r;
  qrs_class_t    cls6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    cls6_r <= qrs_class_t'(sq_cls);
    sa6_r  <= sq_sa;
    sb6_r  <= sq_sb;
    sc6_r  <= sq_sc;
    ma6_r  <= sq_ma;
    mb6_r  <= sq_mb;
    mc6_r  <= sq_mc;
    n1_6_r <= neg_b + {2'b00, sq_root};
    n2_6_r <= neg_b - {2'b00, sq_root};
  end

  // Stage 7: divider operands and quotient signs for each class.
  logic           v7_r, neg1_7_r, neg2_7_r;
  logic [NMW-1:0] num1_7_r, num2_7_r;
  logic [DVW-1:0] den7_r;
  qrs_class_t     cls7_r;
  logic [NW-1:0]  abs_n1, abs_n2;

  assign abs_n1 = n1_6_r[NW-1] ? (~n1_6_r + 1'b1) : n1_6_r;
  assign abs_n2 = n2_6_r[NW-1] ? (~n2_6_r + 1'b1) : n2_6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    cls7_r   <= cls6_r;
    num2_7_r <= abs_n2[NMW-1:0];
    neg2_7_r <= n2_6_r[NW-1] ^ sa6_r;
    case (cls6_r)
      CLS_LINEAR: begin
        den7_r   <= {1'b0, mb6_r};
        num1_7_r <= {2'b00, mc6_r};
        neg1_7_r <= !sc6_r ^ sb6_r;
      end
      CLS_DOUBLE: begin
        den7_r   <= {ma6_r, 1'b0};
        num1_7_r <= {2'b00, mb6_r};
        neg1_7_r <= !sb6_r ^ sa6_r;
      end
      default: begin
        den7_r   <= {ma6_r, 1'b0};
        num1_7_r <= abs_n1[NMW-1:0];
        neg1_7_r <= n1_6_r[NW-1] ^ sa6_r;
      end
    endcase
  end

  // Two root dividers in lockstep.
  logic           dv1_valid, dv2_valid;
  logic [QW-1:0]  dv1_quot, dv2_quot;
  logic [DVW-1:0] dv1_rem, dv2_rem, dv1_den, dv2_den;
  logic [3:0]     dv1_tag;
  logic           dv2_tag;

  qrs_div #(
    .NUM_WIDTH (QW),
    .DEN_WIDTH (DVW),
    .TAG_WIDTH (4)
  ) u_div_first (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v7_r),
    .in_num    ({num1_7_r, {FRAC_BITS{1'b0}}}),
    .in_den    (den7_r),
    .in_tag    ({cls7_r, neg1_7_r}),
    .out_valid (dv1_valid),
    .out_quot  (dv1_quot),
    .out_rem   (dv1_rem),
    .out_den   (dv1_den),
    .out_tag   (dv1_tag)
  );

  qrs_div #(
    .NUM_WIDTH (QW),
    .DEN_WIDTH (DVW),
    .TAG_WIDTH (1)
  ) u_div_second (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v7_r),
    .in_num    ({num2_7_r, {FRAC_BITS{1'b0}}}),
    .in_den    (den7_r),
    .in_tag    (neg2_7_r),
    .out_valid (dv2_valid),
    .out_quot  (dv2_quot),
    .out_rem   (dv2_rem),
    .out_den   (dv2_den),
    .out_tag   (dv2_tag)
  );

  // Stage 8: round to nearest, ties away from zero.
  logic        v8_r, neg1_8_r, neg2_8_r;
  logic [QW:0] q1_8_r, q2_8_r;
  qrs_class_t  cls8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= dv1_valid && dv2_valid;
    end
  end

  always_ff @(posedge clk) begin
    cls8_r   <= qrs_class_t'(dv1_tag[3:1]);
    neg1_8_r <= dv1_tag[0];
    neg2_8_r <= dv2_tag;
    q1_8_r   <= {1'b0, dv1_quot} + (QW + 1)'({dv1_rem, 1'b0} >= {1'b0, dv1_den});
    q2_8_r   <= {1'b0, dv2_quot} + (QW + 1)'({dv2_rem, 1'b0} >= {1'b0, dv2_den});
  end

  // Clamp a rounded magnitude to the field range and apply its sign.
  function automatic logic [W:0] clamp_root(input logic [QW:0] q, input logic neg);
    logic         sat;
    logic [W-1:0] val;
    sat = neg ? (q > HALF_Q) : (q >= HALF_Q);
    if (sat) begin
      val = neg ? ROOT_MIN : ROOT_MAX;
    end else begin
      val = neg ? (~q[W-1:0] + 1'b1) : q[W-1:0];
    end
    return {sat, val};
  endfunction

  // Stage 9: result register.
  logic       out_valid_r;
  qrs_res_t   out_res_r;
  qrs_res_t   res_nxt;
  logic [W:0] c1, c2;

  always_comb begin
    c1                  = clamp_root(q1_8_r, neg1_8_r);
    c2                  = clamp_root(q2_8_r, neg2_8_r);
    res_nxt.root_class  = cls8_r;
    res_nxt.root_first  = '0;
    res_nxt.root_second = '0;
    res_nxt.saturated   = 1'b0;
    case (cls8_r)
      CLS_LINEAR, CLS_DOUBLE: begin
        res_nxt.root_first = c1[W-1:0];
        res_nxt.saturated  = c1[W];
      end
      CLS_TWO: begin
        res_nxt.root_first  = c1[W-1:0];
        res_nxt.root_second = c2[W-1:0];
        res_nxt.saturated   = c1[W] || c2[W];
      end
      default: begin
        res_nxt.saturated = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Every result traces back to a request the fixed latency earlier.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without a matching request");

  // Classes without a root give zero roots and no clamp.
  a_no_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_res.root_class == CLS_ALL_REAL || out_res.root_class == CLS_NONE ||
                  out_res.root_class == CLS_NO_REAL)
    |-> out_res.root_first == '0 && out_res.root_second == '0 && !out_res.saturated)
    else $error("root reported for a class without roots");

  // Only the two-root class carries a second root.
  a_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.root_class != CLS_TWO |-> out_res.root_second == '0)
    else $error("second root outside the two-root class");

  // A clamped single root sits at one end of the range.
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.saturated && out_res.root_class != CLS_TWO
    |-> $unsigned(out_res.root_first) == ROOT_MAX || $unsigned(out_res.root_first) == ROOT_MIN)
    else $error("clamped root not at the range limit");

endmodule
`default_nettype wire

FILE: dv/tb_quadratic_root_solver.sv
// Testbench for the quadratic root solver: random and directed coefficient triples, scoreboard check.
`timescale 1ns / 1ps
module tb_quadratic_root_solver;
  import qrs_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 92;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  qrs_req_t in_req = '0;
  logic out_valid;
  qrs_res_t out_res;
  logic cfg_we = 1'b0;
  logic [TOL_WIDTH-1:0] cfg_wdata = '0;

  int error_count = 0;

  quadratic_root_solver #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Print one mismatch line and count it.
  task automatic report_error(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR at %0t: %s got %h expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Signed rounded quotient (num * 2^FRAC) / den, saturated to 32 bits.
  function automatic logic [31:0] round_div(logic signed [127:0] num,
                                            logic signed [127:0] den,
                                            ref logic sat);
    logic neg;
    logic [127:0] n, d, q, r;
    logic [127:0] lim;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    n = n << FRAC;
    q = n / d;
    r = n % d;
    if ((r << 1) >= d) q = q + 1;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > lim) begin
      sat = 1'b1;
      q = lim;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  // Integer square root, rounded down.
  function automatic logic [63:0] floor_sqrt(logic [127:0] v);
    logic [63:0] res, cand;
    res = '0;
    for (int k = 63; k >= 0; k--) begin
      cand = res | (64'd1 << k);
      if (128'(cand) * 128'(cand) <= v) res = cand;
    end
    return res;
  endfunction

  // Expected solver result for one request under a given tolerance.
  function automatic qrs_res_t solve_roots(qrs_req_t rq, logic [30:0] tol);
    qrs_res_t e;
    logic signed [127:0] a, b, c, disc, s;
    logic [127:0] ma, mb, mc, md;
    logic sat;
    a = rq.coef_a; b = rq.coef_b; c = rq.coef_c;
    ma = (a < 0) ? -a : a; mb = (b < 0) ? -b : b; mc = (c < 0) ? -c : c;
    e = '0; sat = 1'b0;
    if (ma == 0 || ma < tol) begin
      if (mb == 0 || mb < tol) e.root_class = (mc == 0 || mc < tol) ? CLS_ALL_REAL : CLS_NONE;
      else begin
        e.root_class = CLS_LINEAR;
        e.root_first = round_div(-c, b, sat);
      end
    end else begin
      disc = b * b - 4 * a * c;
      md = (disc < 0) ? -disc : disc;
      if (md == 0 || md < (128'(tol) << FRAC)) begin
        e.root_class = CLS_DOUBLE;
        e.root_first = round_div(-b, 2 * a, sat);
      end else if (disc < 0) e.root_class = CLS_NO_REAL;
      else begin
        s = floor_sqrt(md);
        e.root_class = CLS_TWO;
        e.root_first = round_div(-b + s, 2 * a, sat);
        e.root_second = round_div(-b - s, 2 * a, sat);
      end
    end
    e.saturated = sat;
    return e;
  endfunction

  // Scoreboard: holds expected results in request order.
  class root_scoreboard;
    qrs_res_t pending[$];
    logic [30:0] tol;
    function void note_request(qrs_req_t rq);
      pending.push_back(solve_roots(rq, tol));
    endfunction
    task check_result(qrs_res_t got);
      qrs_res_t want;
      if (pending.size() == 0) begin
        report_error("unexpected result", 64'(got), 64'd0);
        return;
      end
      want = pending.pop_front();
      if (got.root_class !== want.root_class)
        report_error("root_class", 64'(got.root_class), 64'(want.root_class));
      if (got.root_first !== want.root_first)
        report_error("root_first", 64'(got.root_first), 64'(want.root_first));
      if (got.root_second !== want.root_second)
        report_error("root_second", 64'(got.root_second), 64'(want.root_second));
      if (got.saturated !== want.saturated)
        report_error("saturated", 64'(got.saturated), 64'(want.saturated));
    endtask
  endclass

  root_scoreboard sb = new();

  // Results are sampled at the edge that accepts them.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_res);
  end

  // Send one request after a random gap; start stays high for back-to-back requests.
  task automatic send_request(qrs_req_t rq);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req <= rq;
    do @(posedge clk); while (busy);
    sb.note_request(rq);
  endtask

  // Wait for the pipeline to drain, then write the tolerance.
  task automatic set_tolerance(logic [30:0] v);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.tol = v;
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 16'hffff)) - 32'sd32768);
      2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      3: return 32'($signed($urandom_range(0, 20)) - 32'sd10) <<< FRAC;
      default: return 32'($signed($urandom_range(0, 32'h000f_ffff)) - 32'sd524288);
    endcase
  endfunction

  // Random request biased toward well-formed quadratics.
  function automatic qrs_req_t rand_request();
    qrs_req_t rq;
    logic signed [31:0] r1, r2;
    rq.coef_a = rand_coef(); rq.coef_b = rand_coef(); rq.coef_c = rand_coef();
    case ($urandom_range(0, 7))
      0: rq.coef_a = $urandom_range(0, 1) ? 32'($urandom_range(0, 4)) : 32'd0;
      1: begin
        rq.coef_a = 0;
        if ($urandom_range(0, 1)) rq.coef_b = 0;
      end
      2: begin
        // Perfect square for a double root.
        r1 = 32'($signed($urandom_range(0, 40)) - 32'sd20);
        rq.coef_a = 32'sd1 <<< FRAC;
        rq.coef_b = -(2 * r1) <<< FRAC;
        rq.coef_c = (r1 * r1) <<< FRAC;
      end
      3: begin
        // Integer roots r1 and r2.
        r1 = 32'($signed($urandom_range(0, 200)) - 32'sd100);
        r2 = 32'($signed($urandom_range(0, 200)) - 32'sd100);
        rq.coef_a = 32'($signed($urandom_range(1, 8))) <<< FRAC;
        rq.coef_b = -(rq.coef_a >>> FRAC) * (r1 + r2) <<< FRAC;
        rq.coef_c = (rq.coef_a >>> FRAC) * r1 * r2 <<< FRAC;
      end
      default: ;
    endcase
    return rq;
  endfunction

  logic [30:0] tol_set[6] = '{31'd0, 31'd1, 31'h7fff_ffff, 31'd65536, 31'd16, 31'd0};
  qrs_req_t directed[$];

  initial begin
    qrs_req_t rq;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    sb.tol = '0;
    @(posedge clk);

    // Directed cases: every class, extremes and exact zeros.
    directed.push_back('{32'd0, 32'd0, 32'd0});
    directed.push_back('{32'd0, 32'd0, 32'sd65536});
    directed.push_back('{32'd0, 32'sd131072, 32'sd65536});
    directed.push_back('{32'd0, 32'sd1, 32'h7fff_ffff});
    directed.push_back('{32'd0, 32'h8000_0000, 32'h8000_0000});
    directed.push_back('{32'sd65536, -32'sd131072, 32'sd65536});
    directed.push_back('{32'sd65536, 32'd0, 32'sd65536});
    directed.push_back('{32'sd65536, 32'd0, -32'sd262144});
    directed.push_back('{32'sd1, 32'h7fff_ffff, 32'h8000_0000});
    directed.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    directed.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
    directed.push_back('{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff});
    directed.push_back('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    directed.push_back('{32'sd1, 32'd0, -32'sd1});
    directed.push_back('{32'sd3, 32'sd5, 32'sd2});
    foreach (directed[i]) send_request(directed[i]);

    // Random phases across several tolerance settings.
    foreach (tol_set[p]) begin
      set_tolerance(p == 4 ? 31'($urandom) : tol_set[p]);
      repeat (170) begin
        rq = rand_request();
        send_request(rq);
      end
    end

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
